>>> hdl/assert_macros.svh
// Assertion helpers for the RTL, used by ascii_decimal_to_servo_pulse.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ADSP_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
	else $error("adsp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ADSP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
	else $error("adsp: next-cycle check failed");

`endif

>>> hdl/adsp_pkg.sv
// ----------------------------------------------------------------------------
// adsp_pkg
// Types and constants of the ASCII decimal to servo pulse converter.
// ----------------------------------------------------------------------------
`default_nettype none

package adsp_pkg;

	localparam int ACC_W   = 32;
	localparam int OFS_W   = 16;
	localparam int GAIN_W  = 12;
	localparam int CMP_W   = 16;
	localparam int CFG_W   = 16;
	localparam int PROD_W  = ACC_W + GAIN_W;

	// divide by 100 as a reciprocal multiply, exact for products below 2^23
	localparam int DIV_IN_W    = 23;
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 30;
	localparam int QMUL_W      = DIV_IN_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

	// products from here on always saturate the compare value
	localparam logic [PROD_W-1:0] SAT_PRODUCT = 44'd6553600;

	localparam logic [OFS_W-1:0]  OFFSET_RESET = 16'd600;
	localparam logic [GAIN_W-1:0] GAIN_RESET   = 12'd889;

	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// configuration register indexes
	localparam logic REG_PULSE_OFFSET    = 1'b0;
	localparam logic REG_GAIN_HUNDREDTHS = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_DIGIT = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

endpackage

`default_nettype wire

>>> hdl/adsp_in_if.sv
// ----------------------------------------------------------------------------
// adsp_in_if
// Received-byte channel: one byte with its chunk markers per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsp_in_if import adsp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       chunk_end;
	logic       finish;

	modport source (output valid, data_byte, has_byte, chunk_end, finish, input ready);
	modport sink   (input valid, data_byte, has_byte, chunk_end, finish, output ready);
endinterface

`default_nettype wire

>>> hdl/adsp_out_if.sv
// ----------------------------------------------------------------------------
// adsp_out_if
// Result channel: servo compare value and parse status per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsp_out_if import adsp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMP_W-1:0] compare_value;
	logic [1:0]       status;

	modport source (output valid, compare_value, status, input ready);
	modport sink   (input valid, compare_value, status, output ready);
endinterface

`default_nettype wire

>>> hdl/ascii_decimal_to_servo_pulse.sv
// Throughput: one byte beat per cycle unless back-pressure holds cmd.ready low; the
//   parse state updates in the accept cycle. Result path: a finishing beat is
//   snapshot at the accepting edge (s1), then the gain multiply (s2), reciprocal
//   multiply for /100 (s3) and offset add + saturate (out), one register each.
// Each result stage moves independently, so bubbles collapse under back-pressure.
// Reset: arst_n clears the parse state and stage valids; offset 600, gain 889.
// ----------------------------------------------------------------------------
// ascii_decimal_to_servo_pulse
// Streams ASCII decimal digits into a 32-bit value and turns each finished
// message into a saturated servo timer compare value plus a status code.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ascii_decimal_to_servo_pulse import adsp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	adsp_in_if.sink               cmd,
	adsp_out_if.source            pulse,
	input  wire logic             cfg_we,
	input  wire logic             cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [OFS_W-1:0]  offset_q;
	logic [GAIN_W-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
			gain_q   <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PULSE_OFFSET:    offset_q <= cfg_wdata[OFS_W-1:0];
				REG_GAIN_HUNDREDTHS: gain_q   <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage handshake: a stage loads when empty or when its data moves on
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_out;
	logic en_s1, en_s2, en_s3, en_out;
	logic fire, done;

	assign en_out    = !v_out || pulse.ready;
	assign en_s3     = !v_s3 || en_out;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign cmd.ready = en_s1;
	assign fire      = cmd.valid && cmd.ready;
	assign done      = fire && cmd.chunk_end && cmd.finish;

	// ------------------------------------------------------------------
	// streaming parse
	// ------------------------------------------------------------------
	logic [ACC_W-1:0] acc_q, acc_n;
	logic             seen_q, seen_n;
	status_t          err_q, err_n;   // ST_OK means no error latched
	logic             skip_q, skip_n;

	logic             take, is_eol, is_digit;
	logic [3:0]       digit;
	logic [ACC_W+3:0] acc_x10, acc_next;
	status_t          final_status;

	assign take     = cmd.has_byte && !skip_q;
	assign is_eol   = (cmd.data_byte == CHAR_CR) || (cmd.data_byte == CHAR_LF);
	assign is_digit = (cmd.data_byte >= CHAR_ZERO) && (cmd.data_byte <= CHAR_NINE);
	assign digit    = cmd.data_byte[3:0];
	// acc*10 as shift-and-add; the top nibble flags a pass beyond 32 bits
	assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
	assign acc_next = acc_x10 + {{ACC_W{1'b0}}, digit};

	always_comb begin
		acc_n  = acc_q;
		seen_n = seen_q;
		err_n  = err_q;
		skip_n = skip_q;
		if (take) begin
			if (is_eol) begin
				skip_n = 1'b1;
			end else begin
				seen_n = 1'b1;
				if (err_q == ST_OK) begin
					if (!is_digit) begin
						err_n = ST_NOT_DIGIT;
					end else if (acc_next[ACC_W+3:ACC_W] != 4'd0) begin
						err_n = ST_OVERFLOW;
					end else begin
						acc_n = acc_next[ACC_W-1:0];
					end
				end
			end
		end
		// end of chunk without finish just re-arms parsing
		if (cmd.chunk_end && !cmd.finish) begin
			skip_n = 1'b0;
		end
		final_status = seen_n ? err_n : ST_EMPTY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			seen_q <= 1'b0;
			err_q  <= ST_OK;
			skip_q <= 1'b0;
		end else if (done) begin
			acc_q  <= '0;
			seen_q <= 1'b0;
			err_q  <= ST_OK;
			skip_q <= 1'b0;
		end else if (fire) begin
			acc_q  <= acc_n;
			seen_q <= seen_n;
			err_q  <= err_n;
			skip_q <= skip_n;
		end
	end

	// ------------------------------------------------------------------
	// result pipeline valids
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_out <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= done;
			if (en_s2)  v_s2  <= v_s1;
			if (en_s3)  v_s3  <= v_s2;
			if (en_out) v_out <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// result datapath
	// s1: snapshot of the finished value and status
	// s2: value * gain; flag products that saturate anyway
	// s3: floor(product / 100) via reciprocal multiply
	// out: offset add, saturate, status
	// ------------------------------------------------------------------
	logic [ACC_W-1:0]    acc_s1;
	status_t             status_s1, status_s2, status_s3;
	logic [DIV_IN_W-1:0] prod_s2;
	logic                big_s2, big_s3;
	logic [CMP_W-1:0]    quo_s3;
	logic [CMP_W-1:0]    cmp_q;
	status_t             status_q;

	logic [PROD_W-1:0]   prod;
	logic [QMUL_W-1:0]   qmul;
	logic [CMP_W:0]      sum;

	assign prod = PROD_W'(acc_s1) * PROD_W'(gain_q);
	assign qmul = QMUL_W'(prod_s2) * QMUL_W'(RECIP_100);
	assign sum  = {1'b0, offset_q} + ((status_s3 == ST_OK) ? {1'b0, quo_s3} : '0);

	always_ff @(posedge clk) begin
		if (en_s1 && done) begin
			acc_s1    <= acc_n;
			status_s1 <= final_status;
		end
		if (en_s2 && v_s1) begin
			prod_s2   <= prod[DIV_IN_W-1:0];
			big_s2    <= (prod >= SAT_PRODUCT);
			status_s2 <= status_s1;
		end
		if (en_s3 && v_s2) begin
			quo_s3    <= qmul[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];
			big_s3    <= big_s2;
			status_s3 <= status_s2;
		end
		if (en_out && v_s3) begin
			if (((status_s3 == ST_OK) && big_s3) || sum[CMP_W]) begin
				cmp_q <= '1;
			end else begin
				cmp_q <= sum[CMP_W-1:0];
			end
			status_q <= status_s3;
		end
	end

	assign pulse.valid         = v_out;
	assign pulse.compare_value = cmp_q;
	assign pulse.status        = status_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`ADSP_ASSERT_NEXT(a_clear_after_finish, clk, arst_n, done,
		(acc_q == '0) && !seen_q && (err_q == ST_OK) && !skip_q)
	`ADSP_ASSERT_NEXT(a_error_sticky, clk, arst_n, (err_q != ST_OK) && !done,
		err_q == $past(err_q))
	`ADSP_ASSERT_NOW(a_error_implies_seen, clk, arst_n, err_q != ST_OK, seen_q)

endmodule

`default_nettype wire

>>> sim/ascii_decimal_to_servo_pulse_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_decimal_to_servo_pulse_tb
// Drives byte beats grouped into chunks into the converter and checks every
// result beat, field by field, against an in-bench prediction of the decimal
// parse and the offset + gain scaling, over several register settings.
// ----------------------------------------------------------------------------

module ascii_decimal_to_servo_pulse_tb;
	import adsp_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int PHASES      = 6;
	localparam int PHASE_BEATS = 84;	// beats of random stimulus per phase

	// one byte-channel beat
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       chunk_end;
		logic       finish;
	} cmd_beat_t;

	// one expected result beat
	typedef struct {
		logic [CMP_W-1:0] compare_value;
		status_t          status;
	} pulse_t;

	// receiver stall patterns
	typedef enum {SINK_OPEN, SINK_MASK, SINK_COIN, SINK_HOLD} sink_mode_t;

	// Tracks the parse of the current message and queues the pulse that each
	// finishing beat must produce.
	class servo_scoreboard;
		logic [OFS_W-1:0]  offset;
		logic [GAIN_W-1:0] gain;
		logic [ACC_W-1:0]  value;
		bit                seen;
		bit                skipping;
		status_t           latched;
		pulse_t            expected_pulses[$];
		int                mismatches;

		function new();
			offset     = 16'd600;
			gain       = 12'd889;
			mismatches = 0;
			clear_message();
		endfunction

		function void clear_message();
			value    = '0;
			seen     = 1'b0;
			skipping = 1'b0;
			latched  = ST_OK;
		endfunction

		function void write_reg(logic idx, logic [CFG_W-1:0] data);
			if (idx == REG_PULSE_OFFSET)
				offset = data[OFS_W-1:0];
			else
				gain = data[GAIN_W-1:0];
		endfunction

		function void take_beat(cmd_beat_t b);
			logic [63:0] next;
			logic [63:0] scaled;
			status_t     st;
			if (b.has_byte && !skipping) begin
				if (b.data_byte == CHAR_CR || b.data_byte == CHAR_LF) begin
					skipping = 1'b1;
				end else begin
					seen = 1'b1;
					// first error wins; later bytes only mark the message non-empty
					if (latched == ST_OK) begin
						if (b.data_byte < CHAR_ZERO || b.data_byte > CHAR_NINE) begin
							latched = ST_NOT_DIGIT;
						end else begin
							next = 64'(value) * 64'd10 + 64'(b.data_byte - CHAR_ZERO);
							if (next > 64'hFFFF_FFFF)
								latched = ST_OVERFLOW;
							else
								value = next[ACC_W-1:0];
						end
					end
				end
			end
			if (b.chunk_end && !b.finish)
				skipping = 1'b0;
			if (b.chunk_end && b.finish) begin
				st = seen ? latched : ST_EMPTY;
				scaled = 64'(offset);
				if (st == ST_OK)
					scaled += (64'(value) * 64'(gain)) / 64'd100;
				if (scaled > 64'hFFFF)
					scaled = 64'hFFFF;
				expected_pulses.push_back('{compare_value: scaled[CMP_W-1:0], status: st});
				clear_message();
			end
		endfunction

		task report(string msg);
			mismatches++;
			$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		task check_pulse(logic [CMP_W-1:0] cmp, logic [1:0] st);
			pulse_t want;
			if (expected_pulses.size() == 0) begin
				report($sformatf("result beat with nothing pending: cmp=%0d status=%0d",
					cmp, st));
			end else begin
				want = expected_pulses.pop_front();
				if (st !== want.status)
					report($sformatf("status %0d, want %s", st, want.status.name()));
				if (cmp !== want.compare_value)
					report($sformatf("compare_value %0d, want %0d", cmp,
						want.compare_value));
			end
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	adsp_in_if  cmd_bus ();
	adsp_out_if pulse_bus ();

	ascii_decimal_to_servo_pulse dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_bus),
		.pulse     (pulse_bus),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	servo_scoreboard model;
	int              taken_beats = 0;	// every accepted byte-channel beat
	int              burst_left  = 0;
	int              cycles      = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Result side. Ready moves at the falling edge following a pattern that is
	// re-picked when a random run length runs out: wide open, a fixed 16-bit mask,
	// a coin toss per cycle, or a hold of random length at the start of each frame.
	// ------------------------------------------------------------------------
	sink_mode_t  sink_mode  = SINK_OPEN;
	int          mode_left  = 0;
	int          hold_len   = 1;
	logic [15:0] stall_mask = 16'hFFFF;
	logic [4:0]  frame      = '0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			sink_mode  = sink_mode_t'($urandom_range(0, 3));
			stall_mask = 16'($urandom) | 16'h0001;
			hold_len   = $urandom_range(1, 12);
			mode_left  = $urandom_range(16, 96);
		end
		mode_left = mode_left - 1;
		frame     = frame + 5'd1;
		case (sink_mode)
			SINK_OPEN: pulse_bus.ready <= 1'b1;
			SINK_MASK: pulse_bus.ready <= stall_mask[frame[3:0]];
			SINK_COIN: pulse_bus.ready <= ($urandom_range(0, 3) != 0);
			default:   pulse_bus.ready <= (int'(frame) >= hold_len);
		endcase
	end

	// Result beats are sampled at the rising edge, before any update lands.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && pulse_bus.valid === 1'b1 && pulse_bus.ready === 1'b1)
			model.check_pulse(pulse_bus.compare_value, pulse_bus.status);
	end

	// ------------------------------------------------------------------------
	// Byte side. Beats go out in bursts of random length; between bursts valid
	// drops for a random gap (sometimes none, so long unbroken runs happen).
	// ------------------------------------------------------------------------
	task automatic push_beat(input logic [7:0] data, input bit has, input bit endc,
		input bit fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				cmd_bus.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left = burst_left - 1;
		@(negedge clk);
		cmd_bus.valid     <= 1'b1;
		cmd_bus.data_byte <= data;
		cmd_bus.has_byte  <= has;
		cmd_bus.chunk_end <= endc;
		cmd_bus.finish    <= fin;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
		model.take_beat('{data, has, endc, fin});
		taken_beats++;
	endtask

	// Whole string in one chunk; the last byte closes it.
	task automatic push_text(input string s, input bit fin);
		for (int i = 0; i < s.len(); i++)
			push_beat(s[i], 1'b1, i == s.len() - 1, fin && (i == s.len() - 1));
	endtask

	// CR or LF, then bytes that must be skipped, then the chunk end.
	task automatic push_tail(input bit fin);
		int junk;
		junk = $urandom_range(0, 3);
		push_beat($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, 1'b1, junk == 0,
			fin && (junk == 0));
		for (int i = 1; i <= junk; i++)
			push_beat(8'($urandom), $urandom_range(0, 3) != 0, i == junk,
				fin && (i == junk));
	endtask

	function automatic longint unsigned pick_value();
		case ($urandom_range(0, 7))
			0:       return 64'($urandom_range(0, 9));
			1:       return 64'($urandom_range(0, 999));
			2:       return 64'($urandom_range(0, 65535));
			3:       return 64'($urandom);
			4:       return 64'hFFFF_FFFF - (($urandom_range(0, 3) == 0) ? 0 :
					$urandom_range(1, 20));
			5:       return 64'h1_0000_0000 + $urandom_range(0, 20);
			6:       return {$urandom, $urandom} % 64'd100_000_000_000;
			default: return 64'($urandom_range(0, 100000));
		endcase
	endfunction

	// A decimal message, possibly spread over several chunks (some cut short by
	// CR/LF with junk after it), optionally with one byte replaced by a
	// non-digit, and closed in one of three ways.
	task automatic send_number(input longint unsigned v, input bit corrupt);
		string      text;
		int         bad_at;
		logic [7:0] c;
		text = $sformatf("%0d", v);
		if ($urandom_range(0, 4) == 0)
			text = {"00", text};
		bad_at = corrupt ? $urandom_range(0, text.len() - 1) : -1;
		for (int i = 0; i < text.len(); i++) begin
			c = text[i];
			if (i == bad_at) begin
				do c = 8'($urandom); while (c >= CHAR_ZERO && c <= CHAR_NINE);
			end
			// a byteless beat without chunk end is ignored, finish or not
			if ($urandom_range(0, 15) == 0)
				push_beat(8'($urandom), 1'b0, 1'b0, 1'($urandom));
			if (i == text.len() - 1) begin
				case ($urandom_range(0, 2))
					0: push_beat(c, 1'b1, 1'b1, 1'b1);
					1: begin
						push_beat(c, 1'b1, 1'b0, 1'b0);
						push_tail(1'b1);
					end
					default: begin
						push_beat(c, 1'b1, 1'b0, 1'b0);
						push_beat(8'($urandom), 1'b0, 1'b1, 1'b1);
					end
				endcase
			end else if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1)) begin
					push_beat(c, 1'b1, 1'b1, 1'b0);
				end else begin
					push_beat(c, 1'b1, 1'b0, 1'b0);
					push_tail(1'b0);
				end
			end else begin
				push_beat(c, 1'b1, 1'b0, 1'b0);
			end
		end
	endtask

	task automatic send_message();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			send_number(pick_value(), 1'b0);
		end else if (kind < 75) begin
			send_number(pick_value(), 1'b1);
		end else if (kind < 85) begin
			// empty message: bare finish, or only skipped bytes before it
			if ($urandom_range(0, 1))
				push_beat(8'($urandom), 1'b0, 1'b1, 1'b1);
			else
				push_tail(1'b1);
		end else begin
			n = $urandom_range(1, 6);
			repeat (n)
				push_beat(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	// Idle the byte side and wait for every pending result, plus the pipeline
	// depth so that a last non-finishing beat has cleared too.
	task automatic settle();
		@(negedge clk);
		cmd_bus.valid <= 1'b0;
		burst_left = 0;
		while (model.expected_pulses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Only called while idle. Gain data carries random upper bits, which the
	// register must drop.
	task automatic apply_settings(input logic [OFS_W-1:0] ofs, input logic [GAIN_W-1:0] gn);
		logic [CFG_W-1:0] gain_word;
		gain_word = {4'($urandom), gn};
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_PULSE_OFFSET;
		cfg_wdata <= ofs;
		@(posedge clk);
		model.write_reg(REG_PULSE_OFFSET, ofs);
		@(negedge clk);
		cfg_idx   <= REG_GAIN_HUNDREDTHS;
		cfg_wdata <= gain_word;
		@(posedge clk);
		model.write_reg(REG_GAIN_HUNDREDTHS, gain_word);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int                phase;
		int                mark;
		logic [OFS_W-1:0]  ofs;
		logic [GAIN_W-1:0] gn;
		model = new();

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = REG_PULSE_OFFSET;
		cfg_wdata         = '0;
		cmd_bus.valid     = 1'b0;
		cmd_bus.data_byte = '0;
		cmd_bus.has_byte  = 1'b0;
		cmd_bus.chunk_end = 1'b0;
		cmd_bus.finish    = 1'b0;
		pulse_bus.ready   = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, at the reset values of offset and gain.
		push_beat(8'h00, 1'b0, 1'b1, 1'b1);	// finish with no byte: empty
		push_text("0", 1'b1);				// smallest value
		push_text("/:", 1'b1);				// just below '0', then just above '9' after the error
		push_beat(8'hFF, 1'b1, 1'b0, 1'b0);	// byte extremes, both non-digits
		push_beat(8'h00, 1'b1, 1'b1, 1'b1);
		// finish without chunk end is ignored; CR skips to the chunk end, and
		// a chunk end without finish lets the parse go on: 79
		push_beat("7", 1'b1, 1'b0, 1'b1);
		push_beat(CHAR_CR, 1'b1, 1'b0, 1'b0);
		push_beat("3", 1'b1, 1'b0, 1'b0);
		push_beat(CHAR_LF, 1'b1, 1'b1, 1'b0);
		push_beat("9", 1'b1, 1'b1, 1'b1);
		push_beat(CHAR_LF, 1'b1, 1'b1, 1'b1);	// only a line break: empty
		push_beat(8'hFF, 1'b0, 1'b0, 1'b0);	// byteless beat, ignored
		push_text("42949672960", 1'b1);		// passes 2^32-1, then a digit after the error

		// Random part over several settings: reset values, both extremes,
		// mixed extremes, then random ones.
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				settle();
				case (phase)
					1:       begin ofs = 16'd0;     gn = 12'd0;    end
					2:       begin ofs = 16'hFFFF;  gn = 12'hFFF;  end
					3:       begin ofs = 16'd0;     gn = 12'hFFF;  end
					4:       begin ofs = 16'($urandom); gn = 12'($urandom); end
					default: begin
						ofs = 16'($urandom_range(0, 2000));
						gn  = 12'($urandom_range(1, 200));
					end
				endcase
				apply_settings(ofs, gn);
			end
			mark = taken_beats;
			while (taken_beats - mark < PHASE_BEATS)
				send_message();
		end

		settle();
		repeat (12) @(posedge clk);
		if (model.mismatches == 0 && model.expected_pulses.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
